[src/gte_pkg.sv]
// shared types, constants and functions of the grid thermal erosion block
package gte_pkg;

    localparam int HEIGHT_BITS  = 16;
    localparam int DEF_MAX_COLS = 64;
    localparam int DEF_MAX_ROWS = 64;
    localparam int TALUS_W      = 15;
    localparam int STRENGTH_W   = 16;
    localparam int SWEEP_W      = 16;
    localparam int GEOM_W       = 7;
    localparam int XFER_W       = 19;
    localparam int SUM_W        = 21;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_RUN   = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEPS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STRENGTH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TALUS       = 3'd4;

    localparam logic signed [SUM_W-1:0] H_MAX_S = 21'sd32767;
    localparam logic signed [SUM_W-1:0] H_MIN_S = -21'sd32768;

    typedef struct packed {
        logic       clear;
        logic       here_en;
        logic       nb_en;
        logic [1:0] nb_idx;
        logic       mul_en;
    } eval_ctl_t;

    function automatic logic [HEIGHT_BITS-1:0] sat_height(input logic signed [SUM_W-1:0] v);
        logic [HEIGHT_BITS-1:0] r;
        if (v > H_MAX_S)
            r = H_MAX_S[HEIGHT_BITS-1:0];
        else if (v < H_MIN_S)
            r = H_MIN_S[HEIGHT_BITS-1:0];
        else
            r = v[HEIGHT_BITS-1:0];
        return r;
    endfunction

endpackage

[src/gte_ram.sv]
// single write port, single read port memory with registered read data
module gte_ram
    import gte_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_COLS * DEF_MAX_ROWS,
    parameter int AW    = $clog2(DEF_MAX_COLS * DEF_MAX_ROWS),
    parameter int DW    = HEIGHT_BITS
)(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/gte_eval.sv]
// steepest drop search over four neighbours and transfer amount multiplier
module gte_eval
    import gte_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  eval_ctl_t              ctl,
    input  logic [HEIGHT_BITS-1:0] din,
    input  logic [TALUS_W-1:0]     talus,
    input  logic [STRENGTH_W-1:0]  strength,
    output logic                   pick_valid,
    output logic [1:0]             pick_idx,
    output logic [XFER_W-1:0]      xfer
);

    logic [HEIGHT_BITS-1:0]     here_reg;
    logic [HEIGHT_BITS-1:0]     best_reg;
    logic                       pick_valid_reg;
    logic [1:0]                 pick_idx_reg;
    logic [XFER_W-1:0]          xfer_reg;
    logic signed [HEIGHT_BITS:0] drop;
    logic                       take;
    logic [HEIGHT_BITS-1:0]     excess;
    logic [2*HEIGHT_BITS-1:0]   prod;

    assign drop   = $signed({here_reg[HEIGHT_BITS-1], here_reg})
                  - $signed({din[HEIGHT_BITS-1], din});
    assign take   = (drop > $signed({2'b00, talus}))
                 && (drop > $signed({1'b0, best_reg}));
    assign excess = best_reg - {1'b0, talus};
    assign prod   = excess * strength;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pick_valid_reg <= 1'b0;
            pick_idx_reg   <= 2'd0;
        end
        else if (ctl.clear)
        begin
            pick_valid_reg <= 1'b0;
            pick_idx_reg   <= 2'd0;
        end
        else if (ctl.nb_en && take)
        begin
            pick_valid_reg <= 1'b1;
            pick_idx_reg   <= ctl.nb_idx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.clear)
        begin
            best_reg <= '0;
        end
        else if (ctl.nb_en && take)
        begin
            best_reg <= drop[HEIGHT_BITS-1:0];
        end
        if (ctl.here_en)
        begin
            here_reg <= din;
        end
        if (ctl.mul_en)
        begin
            // transfer is (drop - talus) * strength / 2 in Q.20, back to Q8.8
            xfer_reg <= prod[2*HEIGHT_BITS-1:13];
        end
    end

    assign pick_valid = pick_valid_reg;
    assign pick_idx   = pick_idx_reg;
    assign xfer       = xfer_reg;

endmodule

[src/grid_thermal_erosion.sv]
// top level: request decode, sweep sequencer and the two height memories
// write and unknown requests go from idle to put; reads pass the read-data state first
// a sweep: copy pass, cell steps per interior cell, write-back, paced by the single
// read port of the height memory; the run ends early once a sweep changes nothing
// one request is handled at a time; a finished result waits in the output register
// reset clears control state, sets config defaults; grid stays undefined until written
module grid_thermal_erosion
    import gte_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,  // cell_x[5:0], cell_z[11:6], height_in[27:12]
    input  logic [1:0]            s_tuser,  // req_type[1:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,  // height_out[15:0]
    output logic                  m_tuser,  // run_done[0]
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CELLS  = MAX_COLS * MAX_ROWS;
    localparam int CELL_AW = $clog2(CELLS);
    localparam int DIM_MAX = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
    localparam int DIM_W   = ($clog2(DIM_MAX + 1) > GEOM_W) ? $clog2(DIM_MAX + 1) : GEOM_W;

    localparam logic [3:0] K_HERE  = 4'd0;
    localparam logic [3:0] K_LEFT  = 4'd1;
    localparam logic [3:0] K_RIGHT = 4'd2;
    localparam logic [3:0] K_DOWN  = 4'd3;
    localparam logic [3:0] K_UP    = 4'd4;
    localparam logic [3:0] K_MUL   = 4'd6;
    localparam logic [3:0] K_WR_C  = 4'd7;
    localparam logic [3:0] K_WR_N  = 4'd8;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_RDATA = 8'b0000_0010,
        ST_PUT   = 8'b0000_0100,
        ST_COPY  = 8'b0000_1000,
        ST_CELL  = 8'b0001_0000,
        ST_BACK  = 8'b0010_0000,
        ST_SWEND = 8'b0100_0000,
        ST_SWDEC = 8'b1000_0000
    } state_t;

    state_t                 state_reg, state_next;
    logic [GEOM_W-1:0]      gw_reg, gh_reg;
    logic [SWEEP_W-1:0]     sweeps_reg;
    logic [STRENGTH_W-1:0]  strength_reg;
    logic [TALUS_W-1:0]     talus_reg;
    logic [DIM_W-1:0]       sx_reg, sx_next, sz_reg, sz_next;
    logic [3:0]             step_reg, step_next;
    logic [SWEEP_W-1:0]     sweep_left_reg, sweep_left_next;
    logic [CELL_AW-1:0]     p_addr_reg, p_addr_next;
    logic                   cp_pend_reg, cp_pend_next;
    logic                   bk_pend_reg, bk_pend_next;
    logic                   chg_reg, chg_next;
    logic                   rd_in_reg, rd_in_next;
    logic [HEIGHT_BITS-1:0] res_h_reg, res_h_next;
    logic                   res_done_reg, res_done_next;
    logic                   out_valid_reg, out_valid_next;
    logic [HEIGHT_BITS-1:0] out_h_reg, out_h_next;
    logic                   out_done_reg, out_done_next;

    logic [1:0]             req;
    logic [5:0]             cell_x, cell_z;
    logic [HEIGHT_BITS-1:0] height_in;
    logic [DIM_W-1:0]       act_w, act_h;
    logic                   in_grid;
    logic [CELL_AW-1:0]     item_idx, scan_idx, pick_addr, cell_raddr;
    logic                   full_last, int_last;

    logic                   h_we, n_we;
    logic [CELL_AW-1:0]     h_waddr, h_raddr, n_waddr, n_raddr;
    logic [HEIGHT_BITS-1:0] h_wdata, n_wdata, hq, nq;

    eval_ctl_t              ctl;
    logic                   pick_valid;
    logic [1:0]             pick_idx;
    logic [XFER_W-1:0]      xfer;
    logic signed [SUM_W-1:0] sum_c, sum_n;

    assign req       = s_tuser;
    assign cell_x    = s_tdata[5:0];
    assign cell_z    = s_tdata[11:6];
    assign height_in = s_tdata[27:12];

    assign act_w = (DIM_W'(gw_reg) > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : DIM_W'(gw_reg);
    assign act_h = (DIM_W'(gh_reg) > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : DIM_W'(gh_reg);
    assign in_grid = (DIM_W'(cell_x) < act_w) && (DIM_W'(cell_z) < act_h);

    assign item_idx = CELL_AW'(32'(cell_z) * MAX_COLS + 32'(cell_x));
    assign scan_idx = CELL_AW'(32'(sz_reg) * MAX_COLS + 32'(sx_reg));

    assign full_last = (sx_reg == act_w - DIM_W'(1)) && (sz_reg == act_h - DIM_W'(1));
    assign int_last  = (sx_reg == act_w - DIM_W'(2)) && (sz_reg == act_h - DIM_W'(2));

    always_comb
    begin
        case (pick_idx)
            2'd0:    pick_addr = scan_idx - CELL_AW'(1);
            2'd1:    pick_addr = scan_idx + CELL_AW'(1);
            2'd2:    pick_addr = scan_idx - CELL_AW'(MAX_COLS);
            default: pick_addr = scan_idx + CELL_AW'(MAX_COLS);
        endcase
        case (step_reg)
            K_LEFT:  cell_raddr = scan_idx - CELL_AW'(1);
            K_RIGHT: cell_raddr = scan_idx + CELL_AW'(1);
            K_DOWN:  cell_raddr = scan_idx - CELL_AW'(MAX_COLS);
            K_UP:    cell_raddr = scan_idx + CELL_AW'(MAX_COLS);
            default: cell_raddr = scan_idx;
        endcase
    end

    // neighbour sequencing for the evaluator
    always_comb
    begin
        ctl.clear   = (state_reg == ST_CELL) && (step_reg == K_HERE);
        ctl.here_en = (state_reg == ST_CELL) && (step_reg == K_LEFT);
        ctl.nb_en   = (state_reg == ST_CELL) && (step_reg >= K_RIGHT) && (step_reg <= K_MUL - 4'd1);
        ctl.nb_idx  = 2'(step_reg - K_RIGHT);
        ctl.mul_en  = (state_reg == ST_CELL) && (step_reg == K_MUL);
    end

    gte_eval u_eval (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .din        (hq),
        .talus      (talus_reg),
        .strength   (strength_reg),
        .pick_valid (pick_valid),
        .pick_idx   (pick_idx),
        .xfer       (xfer)
    );

    assign sum_c = $signed({{(SUM_W-HEIGHT_BITS){nq[HEIGHT_BITS-1]}}, nq})
                 - $signed({{(SUM_W-XFER_W){1'b0}}, xfer});
    assign sum_n = $signed({{(SUM_W-HEIGHT_BITS){nq[HEIGHT_BITS-1]}}, nq})
                 + $signed({{(SUM_W-XFER_W){1'b0}}, xfer});

    // memory ports
    always_comb
    begin
        h_we    = bk_pend_reg
               || ((state_reg == ST_IDLE) && s_tvalid && (req == REQ_WRITE) && in_grid);
        h_waddr = bk_pend_reg ? p_addr_reg : item_idx;
        h_wdata = bk_pend_reg ? nq : height_in;
        case (state_reg)
            ST_COPY, ST_BACK: h_raddr = scan_idx;
            ST_CELL:          h_raddr = cell_raddr;
            default:          h_raddr = item_idx;
        endcase

        n_we    = cp_pend_reg
               || ((state_reg == ST_CELL) && pick_valid
                   && ((step_reg == K_WR_C) || (step_reg == K_WR_N)));
        if (cp_pend_reg)
        begin
            n_waddr = p_addr_reg;
            n_wdata = hq;
        end
        else if (step_reg == K_WR_C)
        begin
            n_waddr = scan_idx;
            n_wdata = sat_height(sum_c);
        end
        else
        begin
            n_waddr = pick_addr;
            n_wdata = sat_height(sum_n);
        end
        n_raddr = ((state_reg == ST_CELL) && (step_reg == K_WR_C)) ? pick_addr : scan_idx;
    end

    gte_ram #(.DEPTH(CELLS), .AW(CELL_AW), .DW(HEIGHT_BITS)) u_height_mem (
        .clk   (clk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .raddr (h_raddr),
        .rdata (hq)
    );

    gte_ram #(.DEPTH(CELLS), .AW(CELL_AW), .DW(HEIGHT_BITS)) u_next_mem (
        .clk   (clk),
        .we    (n_we),
        .waddr (n_waddr),
        .wdata (n_wdata),
        .raddr (n_raddr),
        .rdata (nq)
    );

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        sx_next         = sx_reg;
        sz_next         = sz_reg;
        step_next       = step_reg;
        sweep_left_next = sweep_left_reg;
        p_addr_next     = scan_idx;
        cp_pend_next    = 1'b0;
        bk_pend_next    = 1'b0;
        chg_next        = chg_reg;
        rd_in_next      = rd_in_reg;
        res_h_next      = res_h_reg;
        res_done_next   = res_done_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_h_next      = out_h_reg;
        out_done_next   = out_done_reg;

        if (bk_pend_reg && (nq != hq))
        begin
            chg_next = 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    res_h_next    = '0;
                    res_done_next = 1'b0;
                    state_next    = ST_PUT;
                    case (req)
                        REQ_READ:
                        begin
                            rd_in_next = in_grid;
                            state_next = ST_RDATA;
                        end
                        REQ_RUN:
                        begin
                            res_done_next = 1'b1;
                            if (sweeps_reg != '0)
                            begin
                                sweep_left_next = sweeps_reg;
                                sx_next         = '0;
                                sz_next         = '0;
                                chg_next        = 1'b0;
                                state_next      = ST_COPY;
                            end
                        end
                        default:
                        begin
                            state_next = ST_PUT;
                        end
                    endcase
                end
            end
            ST_RDATA:
            begin
                res_h_next = rd_in_reg ? hq : '0;
                state_next = ST_PUT;
            end
            ST_PUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_h_next     = res_h_reg;
                    out_done_next  = res_done_reg;
                    state_next     = ST_IDLE;
                end
            end
            ST_COPY, ST_BACK:
            begin
                if (state_reg == ST_COPY)
                    cp_pend_next = 1'b1;
                else
                    bk_pend_next = 1'b1;
                if (sx_reg == act_w - DIM_W'(1))
                begin
                    sx_next = '0;
                    sz_next = sz_reg + DIM_W'(1);
                end
                else
                begin
                    sx_next = sx_reg + DIM_W'(1);
                end
                if (full_last)
                begin
                    if (state_reg == ST_BACK)
                    begin
                        state_next = ST_SWEND;
                    end
                    else if ((act_w < DIM_W'(3)) || (act_h < DIM_W'(3)))
                    begin
                        sx_next    = '0;
                        sz_next    = '0;
                        state_next = ST_BACK;
                    end
                    else
                    begin
                        sx_next    = DIM_W'(1);
                        sz_next    = DIM_W'(1);
                        step_next  = K_HERE;
                        state_next = ST_CELL;
                    end
                end
            end
            ST_CELL:
            begin
                step_next = step_reg + 4'd1;
                if (step_reg == K_WR_N)
                begin
                    step_next = K_HERE;
                    if (sx_reg == act_w - DIM_W'(2))
                    begin
                        sx_next = DIM_W'(1);
                        sz_next = sz_reg + DIM_W'(1);
                    end
                    else
                    begin
                        sx_next = sx_reg + DIM_W'(1);
                    end
                    if (int_last)
                    begin
                        sx_next    = '0;
                        sz_next    = '0;
                        state_next = ST_BACK;
                    end
                end
            end
            ST_SWEND:
            begin
                state_next = ST_SWDEC;
            end
            ST_SWDEC:
            begin
                sweep_left_next = sweep_left_reg - SWEEP_W'(1);
                if (chg_reg && (sweep_left_reg != SWEEP_W'(1)))
                begin
                    sx_next    = '0;
                    sz_next    = '0;
                    chg_next   = 1'b0;
                    state_next = ST_COPY;
                end
                else
                begin
                    sweep_left_next = '0;
                    state_next      = ST_PUT;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            gw_reg         <= 7'd64;
            gh_reg         <= 7'd64;
            sweeps_reg     <= 16'd1;
            strength_reg   <= 16'd4096;
            talus_reg      <= 15'd128;
            sx_reg         <= '0;
            sz_reg         <= '0;
            step_reg       <= K_HERE;
            sweep_left_reg <= '0;
            cp_pend_reg    <= 1'b0;
            bk_pend_reg    <= 1'b0;
            chg_reg        <= 1'b0;
            rd_in_reg      <= 1'b0;
            res_done_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_done_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sx_reg         <= sx_next;
            sz_reg         <= sz_next;
            step_reg       <= step_next;
            sweep_left_reg <= sweep_left_next;
            cp_pend_reg    <= cp_pend_next;
            bk_pend_reg    <= bk_pend_next;
            chg_reg        <= chg_next;
            rd_in_reg      <= rd_in_next;
            res_done_reg   <= res_done_next;
            out_valid_reg  <= out_valid_next;
            out_done_reg   <= out_done_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_GRID_WIDTH:  gw_reg       <= cfg_data[GEOM_W-1:0];
                    CFG_GRID_HEIGHT: gh_reg       <= cfg_data[GEOM_W-1:0];
                    CFG_SWEEPS:      sweeps_reg   <= cfg_data[SWEEP_W-1:0];
                    CFG_STRENGTH:    strength_reg <= cfg_data[STRENGTH_W-1:0];
                    CFG_TALUS:       talus_reg    <= cfg_data[TALUS_W-1:0];
                    default:         ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p_addr_reg <= p_addr_next;
        res_h_reg  <= res_h_next;
        out_h_reg  <= out_h_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_h_reg;
    assign m_tuser  = out_done_reg;

    a_pend_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cp_pend_reg && bk_pend_reg))
        else $error("copy and write-back passes overlap");

    a_idle_no_sweeps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (sweep_left_reg == '0))
        else $error("sweeps left while idle");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CELL) |-> (step_reg <= K_WR_N))
        else $error("cell step out of range");

    a_out_from_put: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_PUT))
        else $error("result loaded outside the put state");

    a_done_zero_h: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_done_reg) |-> (out_h_reg == '0))
        else $error("run result carries a height");

endmodule

[verif/testbench.sv]
// testbench for grid_thermal_erosion: queued request driver, in-line predictor, result monitor
`timescale 1ns / 1ps

module testbench;
    import gte_pkg::*;

    localparam logic [1:0] REQ_NONE = 2'd3;
    localparam int GRID_CELLS = DEF_MAX_COLS * DEF_MAX_ROWS;
    localparam int LOAD_DIM = 24;
    localparam int STALL_LIMIT = 60000;

    typedef struct {
        logic [1:0]  kind;
        logic [5:0]  x;
        logic [5:0]  z;
        logic [15:0] h;
    } request_t;

    typedef struct {
        logic [15:0] h;
        logic        done;
    } result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    request_t pending_reqs[$];
    result_t  expected_results[$];
    request_t cur_req;
    int       heights[GRID_CELLS];
    int       scratch[GRID_CELLS];
    int       cols_cfg = 64, rows_cfg = 64, sweeps_cfg = 1, strength_cfg = 4096;
    int       talus_cfg = 128;
    int       errors = 0;
    int       quiet_cycles = 0;
    int       send_gap = 0, recv_gap = 0, hold_left = 0;
    bit       no_idle = 1'b0;
    bit       hold_req = 1'b0;
    bit       taken_flag = 1'b0;

    grid_thermal_erosion dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic int sat16(longint v);
        int r;
        if (v > 32767)
            r = 32767;
        else if (v < -32768)
            r = -32768;
        else
            r = int'(v);
        return r;
    endfunction

    function automatic int active_cols();
        return cols_cfg > DEF_MAX_COLS ? DEF_MAX_COLS : cols_cfg;
    endfunction

    function automatic int active_rows();
        return rows_cfg > DEF_MAX_ROWS ? DEF_MAX_ROWS : rows_cfg;
    endfunction

    function automatic bit erode_sweep(int w, int hh);
        int x, z, i, nx, nz, pick, c, n;
        longint here, d, best, t;
        bit changed;
        changed = 1'b0;
        for (c = 0; c < GRID_CELLS; c++)
            scratch[c] = heights[c];
        for (z = 1; z + 1 < hh; z++)
        begin
            for (x = 1; x + 1 < w; x++)
            begin
                here = heights[z * DEF_MAX_COLS + x];
                best = 0;
                pick = -1;
                for (i = 0; i < 4; i++)
                begin
                    nx = x + (i == 0 ? -1 : (i == 1 ? 1 : 0));
                    nz = z + (i == 2 ? -1 : (i == 3 ? 1 : 0));
                    d = here - heights[nz * DEF_MAX_COLS + nx];
                    if (d > talus_cfg && d > best)
                    begin
                        best = d;
                        pick = i;
                    end
                end
                if (pick >= 0)
                begin
                    t = ((best - talus_cfg) * longint'(strength_cfg)) >>> 13;
                    nx = x + (pick == 0 ? -1 : (pick == 1 ? 1 : 0));
                    nz = z + (pick == 2 ? -1 : (pick == 3 ? 1 : 0));
                    c = z * DEF_MAX_COLS + x;
                    n = nz * DEF_MAX_COLS + nx;
                    scratch[c] = sat16(longint'(scratch[c]) - t);
                    scratch[n] = sat16(longint'(scratch[n]) + t);
                end
            end
        end
        for (c = 0; c < GRID_CELLS; c++)
        begin
            if (scratch[c] != heights[c])
                changed = 1'b1;
            heights[c] = scratch[c];
        end
        return changed;
    endfunction

    function automatic result_t predict_height(request_t r);
        result_t res;
        int w, hh, left;
        bit in_grid;
        w = active_cols();
        hh = active_rows();
        in_grid = (r.x < w) && (r.z < hh);
        res.h = '0;
        res.done = 1'b0;
        if (r.kind == REQ_WRITE)
        begin
            if (in_grid)
                heights[r.z * DEF_MAX_COLS + r.x] = int'($signed(r.h));
        end
        else if (r.kind == REQ_RUN)
        begin
            left = sweeps_cfg;
            while (left > 0)
            begin
                left--;
                if (!erode_sweep(w, hh))
                    left = 0;
            end
            res.done = 1'b1;
        end
        else if (r.kind == REQ_READ)
        begin
            if (in_grid)
                res.h = heights[r.z * DEF_MAX_COLS + r.x][15:0];
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && !taken_flag)
            begin
            end
            else if (send_gap > 0)
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                cur_req = pending_reqs.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {4'b0, cur_req.h, cur_req.z, cur_req.x};
                s_tuser <= cur_req.kind;
                if (!no_idle && $urandom_range(0, 9) == 0)
                    send_gap = $urandom_range(1, 9);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        taken_flag <= s_tvalid && s_tready;
        if (s_tvalid && s_tready)
            expected_results.push_back(predict_height(cur_req));
    end

    // result receiver, with bursts of back-pressure and one long hold-off
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_req && hold_left == 0)
            begin
                hold_req = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!no_idle && $urandom_range(0, 9) == 0)
                    recv_gap = $urandom_range(1, 9);
            end
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result", m_tdata, -1);
            else
            begin
                want = expected_results.pop_front();
                if (m_tdata !== want.h)
                    report_mismatch("height_out", m_tdata, want.h);
                if (m_tuser !== want.done)
                    report_mismatch("run_done", m_tuser, want.done);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val[15:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_GRID_WIDTH:  cols_cfg = val & 8'h7f;
            CFG_GRID_HEIGHT: rows_cfg = val & 8'h7f;
            CFG_SWEEPS:      sweeps_cfg = val & 16'hffff;
            CFG_STRENGTH:    strength_cfg = val & 16'hffff;
            CFG_TALUS:       talus_cfg = val & 16'h7fff;
            default: ;
        endcase
    endtask

    task automatic push_req(logic [1:0] kind, int x, int z, int h);
        request_t r;
        r.kind = kind;
        r.x = x[5:0];
        r.z = z[5:0];
        r.h = h[15:0];
        pending_reqs.push_back(r);
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || expected_results.size() > 0 || s_tvalid)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic set_geometry(int w, int hh, int sw, int st, int ta);
        write_reg(CFG_GRID_WIDTH, w);
        write_reg(CFG_GRID_HEIGHT, hh);
        write_reg(CFG_SWEEPS, sw);
        write_reg(CFG_STRENGTH, st);
        write_reg(CFG_TALUS, ta);
    endtask

    task automatic random_phase(int count, bit allow_run);
        int i, k, w, hh, hv;
        logic [1:0] kind;
        w = active_cols();
        hh = active_rows();
        for (i = 0; i < count; i++)
        begin
            k = $urandom_range(0, 99);
            if (k < 45)
                kind = REQ_WRITE;
            else if (k < 88)
                kind = REQ_READ;
            else if (k < 95 && allow_run)
                kind = REQ_RUN;
            else
                kind = (k < 95) ? REQ_READ : REQ_NONE;
            hv = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 65535)
                                               : $urandom_range(0, 2047) - 1024;
            push_req(kind, $urandom_range(0, (w + 2 > 63) ? 63 : w + 2),
                     $urandom_range(0, (hh + 2 > 63) ? 63 : hh + 2), hv);
        end
    endtask

    initial
    begin
        int i, j, w, hh;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // load the used corner so that no erosion neighbour is ever unwritten
        set_geometry(LOAD_DIM, LOAD_DIM, 1, 4096, 128);
        for (i = 0; i < LOAD_DIM * LOAD_DIM; i++)
            push_req(REQ_WRITE, i % LOAD_DIM, i / LOAD_DIM, $urandom_range(0, 4095) - 2048);
        push_req(REQ_RUN, 0, 0, 0);
        push_req(REQ_READ, LOAD_DIM - 1, LOAD_DIM - 1, 0);
        push_req(REQ_READ, 1, 1, 0);
        drain();

        // saturation, ties, extremes of the fields
        set_geometry(3, 3, 65535, 65535, 0);
        push_req(REQ_WRITE, 1, 1, 32767);
        push_req(REQ_WRITE, 0, 1, -32768);
        push_req(REQ_WRITE, 2, 1, -32768);
        push_req(REQ_WRITE, 1, 0, -32768);
        push_req(REQ_WRITE, 1, 2, -32768);
        push_req(REQ_WRITE, 63, 63, 1234);
        push_req(REQ_READ, 63, 63, 0);
        push_req(REQ_READ, 3, 0, 0);
        push_req(REQ_NONE, 63, 63, 65535);
        drain();
        write_reg(CFG_SWEEPS, 1);
        push_req(REQ_RUN, 63, 63, 65535);
        for (i = 0; i < 3; i++)
            for (j = 0; j < 3; j++)
                push_req(REQ_READ, i, j, 0);
        drain();
        set_geometry(3, 3, 0, 4096, 32767);
        push_req(REQ_RUN, 0, 0, 0);
        push_req(REQ_READ, 1, 1, 0);
        drain();
        write_reg(CFG_SWEEPS, 65535);
        write_reg(CFG_STRENGTH, 0);
        write_reg(CFG_TALUS, 0);
        push_req(REQ_RUN, 0, 0, 0);
        drain();
        set_geometry(2, 127, 3, 4096, 0);
        push_req(REQ_RUN, 0, 0, 0);
        push_req(REQ_WRITE, 1, 63, 77);
        push_req(REQ_READ, 1, 63, 0);
        push_req(REQ_READ, 2, 0, 0);
        drain();

        // long receiver hold-off while requests keep coming
        set_geometry(LOAD_DIM, LOAD_DIM, 1, 4096, 128);
        hold_req = 1'b1;
        random_phase(150, 1'b0);
        drain();

        for (i = 0; i < 9; i++)
        begin
            w = $urandom_range(3, 12);
            hh = $urandom_range(3, 12);
            if (i == 4)
                w = $urandom_range(0, 2);
            if (i == 0)
                set_geometry(w, hh, $urandom_range(0, 6), 65535, 0);
            else
                set_geometry(w, hh, $urandom_range(0, 6), $urandom_range(0, 8192),
                             ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                                         : $urandom_range(0, 600));
            if (i == 8)
                no_idle = 1'b1;
            random_phase(100, 1'b1);
            drain();
        end

        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

[files.f]
src/gte_pkg.sv
src/gte_ram.sv
src/gte_eval.sv
src/grid_thermal_erosion.sv
verif/testbench.sv
